>>> rtl/life_generation_row_stream_core_macros.svh
// Assertion macros used by the checker file.
`ifndef LIFE_GENERATION_ROW_STREAM_CORE_MACROS_SVH
`define LIFE_GENERATION_ROW_STREAM_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, muted during reset.
`define LGRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lgrs check failed");

// Next-cycle implication, sampled on clk, muted during reset.
`define LGRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lgrs check failed");

`endif

>>> rtl/lgrs_pkg.sv
package lgrs_pkg;

  localparam int ROW_W = 64;
  localparam int ROW_CELLS_DEF = 64;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_ONE  = 2'd1;
  localparam logic [1:0] HELD_TWO  = 2'd2;

  typedef struct packed {
    logic first;
    logic second;
    logic first_end;
  } push_t;

endpackage

>>> rtl/lgrs_ifs.sv
interface lgrs_in_if import lgrs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] prev_row;
  logic             last_row;

  modport source (output valid, prev_row, last_row, input ready);
  modport sink (input valid, prev_row, last_row, output ready);
endinterface

interface lgrs_out_if import lgrs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] next_row;
  logic             frame_end;

  modport source (output valid, next_row, frame_end, input ready);
  modport sink (input valid, next_row, frame_end, output ready);
endinterface

>>> rtl/lgrs_lane.sv
module lgrs_lane (
  input  logic [2:0] above,
  input  logic [2:0] here,
  input  logic [2:0] below,
  output logic       alive
);

  logic [3:0] n;

  always_comb begin
    n = 4'(above[0]) + 4'(above[1]) + 4'(above[2])
      + 4'(below[0]) + 4'(below[1]) + 4'(below[2])
      + 4'(here[0]) + 4'(here[2]);
    alive = (n == 4'd3) || ((n == 4'd2) && here[1]);
  end

endmodule

>>> rtl/lgrs_row_eval.sv
module lgrs_row_eval #(
  parameter int ROW_CELLS = 64
) (
  input  logic [ROW_CELLS-1:0] above,
  input  logic [ROW_CELLS-1:0] here,
  input  logic [ROW_CELLS-1:0] below,
  output logic [ROW_CELLS-1:0] result
);

  // one dead cell of padding on each edge
  logic [ROW_CELLS+1:0] above_pad;
  logic [ROW_CELLS+1:0] here_pad;
  logic [ROW_CELLS+1:0] below_pad;

  assign above_pad = {1'b0, above, 1'b0};
  assign here_pad  = {1'b0, here, 1'b0};
  assign below_pad = {1'b0, below, 1'b0};

  for (genvar i = 0; i < ROW_CELLS; i++) begin : g_lane
    lgrs_lane u_lane (
      .above (above_pad[i+2:i]),
      .here  (here_pad[i+2:i]),
      .below (below_pad[i+2:i]),
      .alive (result[i])
    );
  end

endmodule

>>> rtl/lgrs_out_queue.sv
module lgrs_out_queue import lgrs_pkg::*; #(
  parameter int ROW_CELLS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  push_t                push,
  input  logic [ROW_CELLS-1:0] data_a,
  input  logic [ROW_CELLS-1:0] data_b,
  output logic                 room,
  lgrs_out_if.source           next_stream
);

  logic [ROW_CELLS-1:0] q_row [Q_DEPTH];
  logic                 q_end [Q_DEPTH];
  logic [Q_AW-1:0]      wr_ptr;
  logic [Q_AW-1:0]      rd_ptr;
  logic [Q_CW-1:0]      count;
  logic [Q_CW-1:0]      count_next;
  logic                 pop;

  assign pop  = next_stream.valid && next_stream.ready;
  assign room = count <= Q_CW'(Q_DEPTH - 2);

  assign next_stream.valid     = count != '0;
  assign next_stream.next_row  = ROW_W'(q_row[rd_ptr]);
  assign next_stream.frame_end = q_end[rd_ptr];

  assign count_next = count + Q_CW'(push.first) + Q_CW'(push.second) - Q_CW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_AW'(push.first) + Q_AW'(push.second);
      rd_ptr <= rd_ptr + Q_AW'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      q_row[wr_ptr] <= data_a;
      q_end[wr_ptr] <= push.first_end;
    end
    if (push.second) begin
      q_row[wr_ptr + Q_AW'(1)] <= data_b;
      q_end[wr_ptr + Q_AW'(1)] <= 1'b1;
    end
  end

endmodule

>>> rtl/life_generation_row_stream_core.sv
// A released result is registered in the output queue, offered when at its head.
// Throughput: one row per cycle; a bottom row with rows held yields two results,
// drained one per cycle while the sink is ready, from a four-entry output queue
// that stalls input when fewer than two entries are free.
// Reset (rst, synchronous): held rows and the output queue empty; a new frame starts.
module life_generation_row_stream_core import lgrs_pkg::*; #(
  parameter int ROW_CELLS = ROW_CELLS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lgrs_in_if.sink    prev_stream,
  lgrs_out_if.source next_stream
);

  logic [ROW_CELLS-1:0] upper_row;
  logic [ROW_CELLS-1:0] middle_row;
  logic [1:0]           rows_held;

  logic [ROW_CELLS-1:0] row;
  logic [ROW_CELLS-1:0] above_new;
  logic [ROW_CELLS-1:0] res_mid;
  logic [ROW_CELLS-1:0] res_last;
  logic                 held;
  logic                 last;
  logic                 accept;
  logic                 room;
  push_t                push;

  assign row    = prev_stream.prev_row[ROW_CELLS-1:0];
  assign last   = prev_stream.last_row;
  assign held   = rows_held != HELD_NONE;
  assign accept = prev_stream.valid && prev_stream.ready;
  assign prev_stream.ready = room;

  assign above_new = held ? middle_row : '0;

  lgrs_row_eval #(.ROW_CELLS(ROW_CELLS)) u_eval_mid (
    .above  (upper_row),
    .here   (middle_row),
    .below  (row),
    .result (res_mid)
  );

  lgrs_row_eval #(.ROW_CELLS(ROW_CELLS)) u_eval_last (
    .above  (above_new),
    .here   (row),
    .below  ('0),
    .result (res_last)
  );

  always_comb begin
    push.first     = accept && (held || last);
    push.second    = accept && held && last;
    push.first_end = !held;
  end

  lgrs_out_queue #(.ROW_CELLS(ROW_CELLS)) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .data_a      (held ? res_mid : res_last),
    .data_b      (res_last),
    .room        (room),
    .next_stream (next_stream)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_row  <= '0;
      middle_row <= '0;
      rows_held  <= HELD_NONE;
    end else if (accept) begin
      if (last) begin
        upper_row  <= '0;
        middle_row <= '0;
        rows_held  <= HELD_NONE;
      end else begin
        upper_row  <= above_new;
        middle_row <= row;
        rows_held  <= held ? HELD_TWO : HELD_ONE;
      end
    end
  end

endmodule

>>> rtl/lgrs_checker.sv
`include "life_generation_row_stream_core_macros.svh"

module lgrs_checker import lgrs_pkg::*; #(
  parameter int ROW_CELLS = ROW_CELLS_DEF
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ROW_W-1:0] next_row,
  input logic             frame_end
);

  localparam logic [ROW_W-1:0] HIGH_MASK = ~({ROW_W{1'b1}} >> (ROW_W - ROW_CELLS));

  `LGRS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(next_row) && $stable(frame_end))
  `LGRS_ASSERT_NOW(a_high_bits_dead, out_valid, (next_row & HIGH_MASK) == '0)
  `LGRS_ASSERT_NOW(a_stall_needs_backlog, in_valid && !in_ready, out_valid)
  `LGRS_ASSERT_NOW(a_empty_after_reset, $past(rst), !out_valid && in_ready)

endmodule

bind life_generation_row_stream_core lgrs_checker #(.ROW_CELLS(ROW_CELLS)) u_lgrs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (prev_stream.valid),
  .in_ready  (prev_stream.ready),
  .out_valid (next_stream.valid),
  .out_ready (next_stream.ready),
  .next_row  (next_stream.next_row),
  .frame_end (next_stream.frame_end)
);
